// ===== hdl/mpwc_pkg.sv =====
// Package with the field layout, codes and widths of the pulse width capture core.
`timescale 1ns / 1ps

package mpwc_pkg;

    // Item kinds carried in s_tuser.
    typedef enum logic [1:0] {
        KIND_EDGE  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // Configuration register indexes.
    localparam logic REG_CHANNEL_ENABLE = 1'b0;
    localparam logic REG_ACTIVE_EDGE    = 1'b1;

    localparam int CFG_DATA_W = 8;
    localparam int KIND_W     = 2;
    localparam int CHAN_W     = 3;
    localparam int STAMP_W    = 32;
    localparam int WIDTH_W    = 32;
    localparam int OVF_W      = 32;

    // Input data: channel, rising, timestamp, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = KIND_W;
    // Result data: width_channel, width, overflow_total, padded to whole bytes.
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 1;

endpackage

// ===== hdl/multichannel_pulse_width_capture_core.sv =====
// Top level of the multichannel pulse width capture core with per-channel ring FIFOs.
//
//  Channel   Direction  Transfer contents
//  s_        in         tuser: kind; tdata: channel, rising, timestamp
//  m_        out        tuser: found; tdata: width_channel, width, overflow_total
//  cfg_      in         write enable, register index, 8-bit data
//
// An item is processed while it sits in the input register; a read loads its result into
// the output register once the output slot is free, and the core takes one item per clock
// while no read waits for the output slot. The width store is a single-port-write,
// single-port-read memory with registered read data. Reset is synchronous and clears all
// phases, pointers, fill counts, the counter, the configuration registers and valid flags.
// A read waits in the input register while an earlier result is not yet taken.
`timescale 1ns / 1ps

module multichannel_pulse_width_capture_core #(
    parameter int CHANNELS   = 8,
    parameter int FIFO_DEPTH = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] channel, [3] rising, [35:4] timestamp, [39:36] zero
    input  logic [mpwc_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] kind
    input  logic [mpwc_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] width_channel, [34:3] width, [66:35] overflow_total, [71:67] zero
    output logic [mpwc_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] found
    output logic [mpwc_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [mpwc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import mpwc_pkg::*;

    localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS  = $clog2(FIFO_DEPTH + 1);
    localparam int IDX_W     = PTR_BITS + 1;
    localparam int WORD_BITS = (TIME_BITS < WIDTH_W) ? TIME_BITS : WIDTH_W;
    localparam int ADDR_W    = CH_BITS + PTR_BITS;
    localparam int MEM_DEPTH = CHANNELS * (2 ** PTR_BITS);

    localparam logic [CHAN_W:0]     CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS);
    localparam logic [CNT_BITS-1:0] CNT_FULL   = CNT_BITS'(FIFO_DEPTH);
    localparam logic [PTR_BITS-1:0] PTR_LAST   = PTR_BITS'(FIFO_DEPTH - 1);
    localparam logic [IDX_W-1:0]    IDX_DEPTH  = IDX_W'(FIFO_DEPTH);

    // Configuration registers
    logic [CFG_DATA_W-1:0] enable_reg;
    logic [CFG_DATA_W-1:0] edge_mask_reg;

    // Per-channel state
    logic                  in_pulse_reg [CHANNELS];
    logic [TIME_BITS-1:0]  start_reg    [CHANNELS];
    logic [PTR_BITS-1:0]   wp_reg       [CHANNELS];
    logic [CNT_BITS-1:0]   cnt_reg      [CHANNELS];
    logic [OVF_W-1:0]      ovf_reg;

    // Input register
    logic                  in_valid_reg;
    kind_t                 in_kind_reg;
    logic [CHAN_W-1:0]     in_chan_reg;
    logic                  in_rising_reg;
    logic [STAMP_W-1:0]    in_ts_reg;

    // Output register
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [CHAN_W-1:0]     out_chan_reg;
    logic [OVF_W-1:0]      out_ovf_reg;
    logic [WORD_BITS-1:0]  rd_data_reg;

    logic [WORD_BITS-1:0]  store_mem [0:MEM_DEPTH-1];

    logic                  can_out;
    logic                  proceed;
    logic                  is_edge;
    logic                  is_read;
    logic                  is_clear;
    logic [CH_BITS-1:0]    sel;
    logic                  chan_ok;
    logic                  active_rising;
    logic                  start_hit;
    logic                  push_hit;
    logic                  push_fire;
    logic [PTR_BITS-1:0]   cur_wp;
    logic [CNT_BITS-1:0]   cur_cnt;
    logic [PTR_BITS-1:0]   wp_next;
    logic [TIME_BITS-1:0]  diff;
    logic                  any_ne;
    logic [CH_BITS-1:0]    pop_ch;
    logic [IDX_W-1:0]      pop_a;
    logic [IDX_W-1:0]      pop_b;
    logic [IDX_W-1:0]      pop_idx;
    logic                  pop_fire;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;

    assign can_out  = !out_valid_reg || m_tready;
    assign is_edge  = (in_kind_reg == KIND_EDGE);
    assign is_read  = (in_kind_reg == KIND_READ);
    assign is_clear = (in_kind_reg == KIND_CLEAR);
    // Only a read needs the output slot; other kinds pass straight through.
    assign proceed  = in_valid_reg && (!is_read || can_out);
    assign s_tready = !in_valid_reg || proceed;

    // Edge handling for the addressed channel
    assign sel           = in_chan_reg[CH_BITS-1:0];
    assign chan_ok       = ({1'b0, in_chan_reg} < CHAN_LIMIT) && enable_reg[in_chan_reg];
    assign active_rising = edge_mask_reg[in_chan_reg];

    always_comb begin
        cur_wp  = '0;
        cur_cnt = '0;
        diff    = '0;
        if (chan_ok) begin
            cur_wp  = wp_reg[sel];
            cur_cnt = cnt_reg[sel];
            diff    = TIME_BITS'(in_ts_reg) - start_reg[sel];
        end
    end

    assign start_hit = proceed && is_edge && chan_ok && !in_pulse_reg[sel]
                       && (in_rising_reg == active_rising);
    assign push_hit  = is_edge && chan_ok && in_pulse_reg[sel]
                       && (in_rising_reg != active_rising);
    assign push_fire = proceed && push_hit;
    assign wp_next   = (cur_wp == PTR_LAST) ? '0 : cur_wp + 1'b1;
    assign wr_addr   = {sel, cur_wp};

    // Lowest-numbered channel that holds a width
    always_comb begin
        any_ne = 1'b0;
        pop_ch = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (cnt_reg[c] != '0) begin
                any_ne = 1'b1;
                pop_ch = CH_BITS'(c);
            end
        end
    end

    // Oldest entry sits fill_count places behind the write pointer, modulo the depth.
    always_comb begin
        pop_a = {1'b0, wp_reg[pop_ch]};
        pop_b = IDX_W'(cnt_reg[pop_ch]);
        if (pop_a >= pop_b) begin
            pop_idx = pop_a - pop_b;
        end else begin
            pop_idx = pop_a + IDX_DEPTH - pop_b;
        end
    end

    assign pop_fire = proceed && is_read && any_ne;
    assign rd_addr  = {pop_ch, pop_idx[PTR_BITS-1:0]};

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            store_mem[wr_addr] <= diff[WORD_BITS-1:0];
        end
        if (pop_fire) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg   <= kind_t'(s_tuser[KIND_W-1:0]);
            in_chan_reg   <= s_tdata[CHAN_W-1:0];
            in_rising_reg <= s_tdata[CHAN_W];
            in_ts_reg     <= s_tdata[CHAN_W+STAMP_W:CHAN_W+1];
        end
    end

    // Configuration and per-channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= '0;
            edge_mask_reg <= '0;
            ovf_reg       <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                in_pulse_reg[c] <= 1'b0;
                start_reg[c]    <= '0;
                wp_reg[c]       <= '0;
                cnt_reg[c]      <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CHANNEL_ENABLE: begin
                    enable_reg <= cfg_data;
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (!cfg_data[c]) begin
                            in_pulse_reg[c] <= 1'b0;
                        end
                    end
                end
                REG_ACTIVE_EDGE: begin
                    edge_mask_reg <= cfg_data;
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (cfg_data[c] != edge_mask_reg[c]) begin
                            in_pulse_reg[c] <= 1'b0;
                        end
                    end
                end
                default: begin
                    enable_reg <= enable_reg;
                end
            endcase
        end else if (proceed && is_clear) begin
            ovf_reg <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                in_pulse_reg[c] <= 1'b0;
                start_reg[c]    <= '0;
                wp_reg[c]       <= '0;
                cnt_reg[c]      <= '0;
            end
        end else begin
            if (start_hit) begin
                start_reg[sel]    <= TIME_BITS'(in_ts_reg);
                in_pulse_reg[sel] <= 1'b1;
            end
            if (push_fire) begin
                in_pulse_reg[sel] <= 1'b0;
                wp_reg[sel]       <= wp_next;
                // A full FIFO loses its oldest entry to the new width.
                if (cur_cnt == CNT_FULL) begin
                    ovf_reg <= ovf_reg + 1'b1;
                end else begin
                    cnt_reg[sel] <= cur_cnt + 1'b1;
                end
            end
            if (pop_fire) begin
                cnt_reg[pop_ch] <= cnt_reg[pop_ch] - 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proceed && is_read) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && is_read) begin
            out_found_reg <= any_ne;
            out_chan_reg  <= any_ne ? CHAN_W'(pop_ch) : '0;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {5'b0, out_ovf_reg,
                       out_found_reg ? WIDTH_W'(rd_data_reg) : {WIDTH_W{1'b0}},
                       out_chan_reg};

endmodule
